FILE: src/cfst_pkg.sv
// Shared types, constants and slot-count tables of the CEC frame slot transmitter.
`default_nettype none
package cfst_pkg;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam int unsigned PHASE_W = 4;
	localparam int unsigned SLOT_W  = 6;

	localparam logic [PHASE_W-1:0] PHASE_START = 4'd0;
	localparam logic [PHASE_W-1:0] PHASE_DATA0 = 4'd1;
	localparam logic [PHASE_W-1:0] PHASE_DATA7 = 4'd8;
	localparam logic [PHASE_W-1:0] PHASE_EOM   = 4'd9;
	localparam logic [PHASE_W-1:0] PHASE_ACK   = 4'd10;

	localparam logic MODE_300US = 1'b0;
	localparam logic MODE_100US = 1'b1;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_ONE   = 2'd1,
		KIND_ZERO  = 2'd2
	} bit_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SEND = 2'b10
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic push;      // write store, bump fill count
		logic start;     // rewind frame position
		logic tick_send; // advance one slot
		logic tick_idle; // release the line
		logic clear;     // frame done: empty the store
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic store_full;
		logic frame_done; // the current slot is the last of the frame
	} dp_status_t;

	function automatic logic [SLOT_W-1:0] low_slots(input logic mode, input bit_kind_t kind);
		logic [SLOT_W-1:0] n;
		n = 6'd15;
		case (kind)
			KIND_START: n = (mode == MODE_100US) ? 6'd37 : 6'd12;
			KIND_ONE:   n = (mode == MODE_100US) ? 6'd6  : 6'd2;
			default:    n = (mode == MODE_100US) ? 6'd15 : 6'd5;
		endcase
		return n;
	endfunction

	function automatic logic [SLOT_W-1:0] total_slots(input logic mode, input bit_kind_t kind);
		logic [SLOT_W-1:0] n;
		n = 6'd24;
		case (kind)
			KIND_START: n = (mode == MODE_100US) ? 6'd45 : 6'd15;
			default:    n = (mode == MODE_100US) ? 6'd24 : 6'd8;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

FILE: src/cfst_ctrl.sv
// Controller state machine of the CEC frame slot transmitter.
`default_nettype none
module cfst_ctrl
	import cfst_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic       cmd,
	input  wire logic       last_byte,
	input  wire dp_status_t status,
	output dp_cmd_t         dp_cmd,
	output logic            reject,
	output logic            busy_next
);

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		dp_cmd  = '0;
		reject  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cmd == CMD_PUSH) begin
					if (status.store_full) begin
						reject = 1'b1;
					end else begin
						dp_cmd.push = 1'b1;
						if (last_byte) begin
							dp_cmd.start = 1'b1;
							state_d      = ST_SEND;
						end
					end
				end else if (accept) begin
					dp_cmd.tick_idle = 1'b1;
				end
			end
			ST_SEND: begin
				if (accept && cmd == CMD_PUSH) begin
					reject = 1'b1;
				end else if (accept) begin
					dp_cmd.tick_send = 1'b1;
					if (status.frame_done) begin
						dp_cmd.clear = 1'b1;
						state_d      = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy_next = (state_d == ST_SEND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

FILE: src/cfst_datapath.sv
// Datapath of the CEC frame slot transmitter: byte store, frame position and slot counter.
`default_nettype none
module cfst_datapath
	import cfst_pkg::*;
#(
	parameter int unsigned MAX_BYTES = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       slot_mode,
	input  wire logic [7:0] data_byte,
	input  wire dp_cmd_t    dp_cmd,
	output dp_status_t      status,
	output logic            level_next
);

	localparam int unsigned BW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam int unsigned CW = $clog2(MAX_BYTES + 1);

	logic [7:0]         store_q [MAX_BYTES];
	logic [CW-1:0]      loaded_q;
	logic [BW-1:0]      cur_q;
	logic [PHASE_W-1:0] phase_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               level_q;

	bit_kind_t          kind;
	logic [7:0]         cur_data;
	logic [PHASE_W-1:0] bit_sel;
	logic               last_cur;
	logic [SLOT_W-1:0]  slot_inc;
	logic               bit_end;

	assign cur_data = store_q[cur_q];
	assign bit_sel  = PHASE_DATA7 - phase_q;
	assign last_cur = ((CW'(cur_q) + CW'(1)) >= loaded_q);

	always_comb begin
		kind = KIND_ZERO;
		if (phase_q == PHASE_START) begin
			kind = KIND_START;
		end else if (phase_q <= PHASE_DATA7) begin
			kind = cur_data[bit_sel[2:0]] ? KIND_ONE : KIND_ZERO;
		end else if (phase_q == PHASE_EOM) begin
			kind = last_cur ? KIND_ONE : KIND_ZERO;
		end
	end

	assign slot_inc = slot_q + SLOT_W'(1);
	assign bit_end  = (slot_inc >= total_slots(slot_mode, kind));

	assign status.store_full = (loaded_q == CW'(MAX_BYTES));
	assign status.frame_done = bit_end && (phase_q == PHASE_ACK) && last_cur;

	always_comb begin
		level_next = level_q;
		if (dp_cmd.tick_idle) begin
			level_next = 1'b1;
		end else if (dp_cmd.tick_send) begin
			level_next = (slot_q >= low_slots(slot_mode, kind));
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.push) begin
			store_q[loaded_q[BW-1:0]] <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
			cur_q    <= '0;
			phase_q  <= PHASE_START;
			slot_q   <= '0;
			level_q  <= 1'b1;
		end else begin
			level_q <= level_next;
			if (dp_cmd.push) begin
				loaded_q <= loaded_q + CW'(1);
			end
			if (dp_cmd.start || dp_cmd.clear) begin
				cur_q   <= '0;
				phase_q <= PHASE_START;
				slot_q  <= '0;
			end else if (dp_cmd.tick_send) begin
				if (bit_end) begin
					slot_q <= '0;
					if (phase_q == PHASE_ACK) begin
						// next byte: skip the start bit
						phase_q <= PHASE_DATA0;
						cur_q   <= cur_q + BW'(1);
					end else begin
						phase_q <= phase_q + PHASE_W'(1);
					end
				end else begin
					slot_q <= slot_inc;
				end
			end
			if (dp_cmd.clear) begin
				loaded_q <= '0;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.push |-> !status.store_full)
		else $error("push into a full store");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PHASE_ACK)
		else $error("bit phase out of range");

	a_send_pos: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.tick_send |-> (CW'(cur_q) < loaded_q))
		else $error("sending past the loaded bytes");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.clear && !dp_cmd.push) |=> (loaded_q == '0) && (phase_q == PHASE_START))
		else $error("frame end did not empty the store");

endmodule
`default_nettype wire

FILE: src/cec_frame_slot_transmitter_unit.sv
// Top level of the CEC frame slot transmitter: config register, controller, datapath, output skid.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------------
//  input    | in        | in_valid / in_stall     | cmd, data_byte, last_byte
//  output   | out       | out_valid / out_stall   | line_level, busy_res, rejected
//  config   | in        | slot_mode_we            | slot_mode_wdata
//
//  Every accepted word (push or slot tick) is handled in the cycle it is taken and gives one result
//  word, registered in the output register or, when that is held, in the skid entry;
//  one word per cycle sustained while in_stall is low. The limit is the single slot counter step
//  and level pick on the tick path. A two-entry output stage (register plus skid) holds results;
//  in_stall rises only when both entries are full.
//  Reset (arst_n low) empties the store, idles the controller and sets the datapath line level high.
//  The byte store has no reset; only entries below the fill count are ever read.
`default_nettype none
module cec_frame_slot_transmitter_unit
	import cfst_pkg::*;
#(
	parameter int unsigned MAX_BYTES = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       slot_mode_we,
	input  wire logic       slot_mode_wdata,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       cmd,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            line_level,
	output logic            busy_res,
	output logic            rejected
);

	logic       slot_mode_q;
	logic       in_accept;
	logic       out_take;
	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;
	logic       reject;
	logic       busy_next;
	logic       level_next;

	// output register and skid entry
	logic       out_valid_q, skid_valid_q;
	logic       out_level_q, out_busy_q, out_rej_q;
	logic       skid_level_q, skid_busy_q, skid_rej_q;
	logic       out_load;

	// Take a new word whenever the skid entry is free.
	assign in_stall  = skid_valid_q;
	assign in_accept = in_valid && !skid_valid_q;
	assign out_take  = out_valid_q && !out_stall;
	assign out_load  = out_take || !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_mode_q <= MODE_300US;
		end else if (slot_mode_we) begin
			slot_mode_q <= slot_mode_wdata;
		end
	end

	cfst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_accept),
		.cmd       (cmd),
		.last_byte (last_byte),
		.status    (dp_status),
		.dp_cmd    (dp_cmd),
		.reject    (reject),
		.busy_next (busy_next)
	);

	cfst_datapath #(
		.MAX_BYTES (MAX_BYTES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.slot_mode  (slot_mode_q),
		.data_byte  (data_byte),
		.dp_cmd     (dp_cmd),
		.status     (dp_status),
		.level_next (level_next)
	);

	// Valid bits: a fresh result goes to the output register when it is free, else to skid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_load) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_accept;
			end
		end else if (in_accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload: advance skid into the output register, or capture the new result.
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (skid_valid_q) begin
				out_level_q <= skid_level_q;
				out_busy_q  <= skid_busy_q;
				out_rej_q   <= skid_rej_q;
			end else begin
				out_level_q <= level_next;
				out_busy_q  <= busy_next;
				out_rej_q   <= reject;
			end
		end else if (in_accept) begin
			skid_level_q <= level_next;
			skid_busy_q  <= busy_next;
			skid_rej_q   <= reject;
		end
	end

	assign out_valid  = out_valid_q;
	assign line_level = out_level_q;
	assign busy_res   = out_busy_q;
	assign rejected   = out_rej_q;

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry filled ahead of output register");

	a_reject_push: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && cmd == CMD_TICK) |-> !reject)
		else $error("tick flagged as rejected");

	a_busy_push: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && cmd == CMD_PUSH && dp_cmd.push && last_byte) |-> busy_next)
		else $error("last byte did not start a frame");

endmodule
`default_nettype wire
